/* sv/assert_macros.svh */
// Assertion macros for the PCM frame converter, included by pcmfs_queue.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* sv/pcmfs_pkg.sv */
// Types and constants for the PCM frame to stereo 16-bit converter.
// Used by the front, queue, back and top level modules.
package pcmfs_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_IS_FLOAT    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_BYTES = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CHANNELS    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_ALIGN = 2'd3;

  typedef struct packed {
    logic       is_float;
    logic [2:0] sample_bytes;
    logic [5:0] channel_count;
    logic [6:0] block_align;
  } cfg_t;

  // A completed frame handed from the front to the back.
  typedef struct packed {
    logic        is_float;
    logic [2:0]  sample_bytes;
    logic        mono;
    logic [31:0] left_raw;
    logic [31:0] right_raw;
  } frame_t;

  // Integer conversion to the top 16 bits.
  function automatic logic [15:0] int_convert(input logic [2:0] nbytes,
                                              input logic [31:0] raw);
    logic [15:0] res;
    begin
      unique case (nbytes)
        3'd1:    res = {raw[7:0] ^ 8'h80, 8'h00};
        3'd2:    res = raw[15:0];
        3'd3:    res = raw[23:8];
        default: res = raw[31:16];
      endcase
      return res;
    end
  endfunction

endpackage

/* sv/pcmfs_front.sv */
// Front part: assembles bytes into frames and classifies the configuration.
// Depends on pcmfs_pkg.
module pcmfs_front #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcmfs_pkg::cfg_t    cfg,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         data_byte,
  input  logic               packet_end,
  output logic               frm_valid,
  input  logic               frm_ready,
  output pcmfs_pkg::frame_t  frm
);

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] left_r, left_nxt, right_r, right_nxt;
  logic        cfg_ok;
  logic [8:0]  need;
  logic [6:0]  pos_inc;
  logic [2:0]  rpos;
  logic        done;
  logic        take;

  always_comb begin
    need = 9'(cfg.sample_bytes) * 9'(cfg.channel_count);
    cfg_ok = (cfg.sample_bytes >= 3'd1) && (cfg.sample_bytes <= 3'd4)
          && !(cfg.is_float && cfg.sample_bytes != 3'd4)
          && (cfg.channel_count != 6'd0) && (cfg.block_align != 7'd0)
          && (9'(cfg.block_align) <= 9'(MAX_FRAME_BYTES))
          && (9'(cfg.block_align) >= need);
  end

  assign pos_inc    = 7'(pos_r) + 7'd1;
  assign done       = cfg_ok && (pos_inc >= cfg.block_align);
  // A byte that completes a frame waits for room in the queue.
  assign byte_ready = !done || frm_ready;
  assign take       = byte_valid && byte_ready;
  assign rpos       = 3'(pos_r) - cfg.sample_bytes;

  always_comb begin
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (take) begin
      if (!cfg_ok) begin
        pos_nxt = '0;
      end else begin
        if (7'(pos_r) < 7'(cfg.sample_bytes)) begin
          left_nxt[8*pos_r[1:0] +: 8] = data_byte;
        end else if (cfg.channel_count > 6'd1
                     && 7'(pos_r) < 7'({cfg.sample_bytes, 1'b0})) begin
          right_nxt[8*rpos[1:0] +: 8] = data_byte;
        end
        pos_nxt = done ? '0 : pos_inc[5:0];
        if (packet_end) pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign frm_valid        = byte_valid && done;
  assign frm.is_float     = cfg.is_float;
  assign frm.sample_bytes = cfg.sample_bytes;
  assign frm.mono         = (cfg.channel_count <= 6'd1);
  assign frm.left_raw     = left_nxt;
  assign frm.right_raw    = right_nxt;

endmodule

/* sv/pcmfs_queue.sv */
// Two-entry queue between the front and back parts.
// Depends on pcmfs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcmfs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  pcmfs_pkg::frame_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output pcmfs_pkg::frame_t rd_data
);

  pcmfs_pkg::frame_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `ASSERT_IMPLIES(a_ptr_match, clk, rst_n, cnt_r != 2'd1, wp_r == rp_r)
  `ASSERT_NEXT(a_full_hold, clk, rst_n, cnt_r == 2'd2 && !pop, cnt_r == 2'd2)

endmodule

/* sv/pcmfs_back.sv */
// Back part: converts a frame to a stereo 16-bit pair, two stages.
// Depends on pcmfs_pkg.
module pcmfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frm_valid,
  output logic              frm_ready,
  input  pcmfs_pkg::frame_t frm,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       left_sample,
  output logic [15:0]       right_sample
);

  // Float path: v * 32767 in single precision, round to nearest even,
  // then truncate toward zero. Stage 1 multiplies mantissa, stage 2 rounds.
  typedef struct packed {
    logic        is_float;
    logic [2:0]  sample_bytes;
    logic        mono;
    logic [31:0] lraw;
    logic [31:0] rraw;
    logic [39:0] lprod;
    logic [39:0] rprod;
  } s1_t;

  s1_t  s1_r;
  logic s1_v_r, out_v_r;
  logic [15:0] l_r, r_r;
  logic adv1, adv2;

  assign out_valid    = out_v_r;
  assign left_sample  = l_r;
  assign right_sample = r_r;
  assign adv2      = s1_v_r && (!out_v_r || out_ready);
  assign frm_ready = !s1_v_r || adv2;
  assign adv1      = frm_valid && frm_ready;

  function automatic logic [39:0] fmul(input logic [31:0] raw);
    return 40'({1'b1, raw[22:0]}) * 40'd32767;
  endfunction

  // Rounds the 39-bit product to 24 bits (nearest even) and truncates.
  function automatic logic [15:0] fconv(input logic [31:0] raw,
                                        input logic [39:0] prod);
    logic [7:0]  e;
    logic        big;
    logic [24:0] m;
    logic [38:0] p;
    logic        g, st;
    logic [7:0]  ee;
    logic [39:0] sh;
    logic [15:0] mag;
    int          s;
    begin
      e   = raw[30:23];
      p   = prod[38:0];
      big = p[38];
      // Keep 24 significant bits of the product.
      if (big) begin
        m  = 25'(p[38:15]);
        g  = p[14];
        st = |p[13:0];
      end else begin
        m  = 25'(p[37:14]);
        g  = p[13];
        st = |p[12:0];
      end
      if (g && (st || m[0])) m = m + 25'd1;
      ee = e + 8'(big);
      if (m[24]) begin
        m  = m >> 1;
        ee = ee + 8'd1;
      end
      // Value = m * 2^(ee - 127 - 23 + 14); integer part needs ee >= 112.
      mag = '0;
      if (ee >= 8'd112 && ee < 8'd144) begin
        s   = int'(ee) - 112;
        sh  = 40'(m) << s;
        mag = sh[39:24];
      end
      if (e == 8'd0) mag = '0;
      if (e == 8'hFF && raw[22:0] != '0) begin
        fconv = '0;
      end else if (!raw[31] && raw[30:0] >= 31'h3F80_0000) begin
        fconv = 16'h7FFF;
      end else if (raw[31] && raw[30:0] >= 31'h3F80_0000) begin
        fconv = 16'h8000;
      end else begin
        fconv = raw[31] ? 16'(-mag) : mag;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r.is_float     <= frm.is_float;
      s1_r.sample_bytes <= frm.sample_bytes;
      s1_r.mono         <= frm.mono;
      s1_r.lraw         <= frm.left_raw;
      s1_r.rraw         <= frm.right_raw;
      s1_r.lprod        <= fmul(frm.left_raw);
      s1_r.rprod        <= fmul(frm.right_raw);
    end
    if (adv2) begin
      if (s1_r.is_float) begin
        l_r <= fconv(s1_r.lraw, s1_r.lprod);
        r_r <= s1_r.mono ? fconv(s1_r.lraw, s1_r.lprod)
                         : fconv(s1_r.rraw, s1_r.rprod);
      end else begin
        l_r <= pcmfs_pkg::int_convert(s1_r.sample_bytes, s1_r.lraw);
        r_r <= pcmfs_pkg::int_convert(s1_r.sample_bytes,
                                      s1_r.mono ? s1_r.lraw : s1_r.rraw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= 1'b1;
      else if (adv2) s1_v_r <= 1'b0;
      if (adv2) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

endmodule

/* sv/pcm_frame_to_stereo16.sv */
// Top level of the PCM frame to stereo 16-bit converter.
// Depends on pcmfs_pkg, pcmfs_front, pcmfs_queue and pcmfs_back.
//
// Channel | Dir | Payload
// in_     | in  | tdata = data_byte[7:0]; tlast = packet_end
// out_    | out | tdata = left_sample[15:0], right_sample[31:16]
// cfg_    | in  | cfg_index[1:0], cfg_data[6:0]
//
// One byte is accepted per cycle; a byte that completes a frame waits
// only when the two-entry frame queue is full.
// The edge that accepts a frame's last byte writes it into the queue; the
// back part then registers the mantissa multiply and then the rounded and
// converted pair, which raises out_tvalid.
// Reset (rst_n low, synchronous) clears framing, raw bytes and valid flags.
module pcm_frame_to_stereo16 #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // data_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // left_sample[15:0], right_sample[31:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  pcmfs_pkg::cfg_t   cfg_r;
  pcmfs_pkg::frame_t f_frm, q_frm;
  logic f_v, f_rdy, q_v, q_rdy;
  logic [15:0] lft, rgt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.is_float      <= 1'b0;
      cfg_r.sample_bytes  <= 3'd2;
      cfg_r.channel_count <= 6'd2;
      cfg_r.block_align   <= 7'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcmfs_pkg::REG_IS_FLOAT:     cfg_r.is_float      <= cfg_data[0];
        pcmfs_pkg::REG_SAMPLE_BYTES: cfg_r.sample_bytes  <= cfg_data[2:0];
        pcmfs_pkg::REG_CHANNELS:     cfg_r.channel_count <= cfg_data[5:0];
        default:                     cfg_r.block_align   <= cfg_data;
      endcase
    end
  end

  pcmfs_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .byte_valid(in_tvalid), .byte_ready(in_tready),
    .data_byte(in_tdata), .packet_end(in_tlast),
    .frm_valid(f_v), .frm_ready(f_rdy), .frm(f_frm)
  );

  pcmfs_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_v), .wr_ready(f_rdy), .wr_data(f_frm),
    .rd_valid(q_v), .rd_ready(q_rdy), .rd_data(q_frm)
  );

  pcmfs_back u_back (
    .clk, .rst_n,
    .frm_valid(q_v), .frm_ready(q_rdy), .frm(q_frm),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .left_sample(lft), .right_sample(rgt)
  );

  assign out_tdata = {rgt, lft};

endmodule

/* tb/tb.sv */
// Self-checking bench for pcm_frame_to_stereo16: a byte driver and a pair monitor
// run against a built-in frame converter predictor over many register settings.
// Depends on pcmfs_pkg and the pcm_frame_to_stereo16 RTL.
module tb;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic       fl;
    logic [2:0] sb;
    logic [5:0] cc;
    logic [6:0] ba;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // data_byte[7:0]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // left_sample[15:0], right_sample[31:16]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = pcmfs_pkg::REG_IS_FLOAT;
  logic [6:0]  cfg_data = 7'd0;

  pcm_frame_to_stereo16 dut (.*);

  always #4 clk = ~clk;

  byte_item_t  byte_q[$];
  logic [31:0] pair_q[$];
  int          send_pct = 0;
  int          recv_pct = 0;
  int          hold_token = 0;
  int          errors = 0;

  // Predictor copy of the registers and framing state.
  setting_t    cur = '{1'b0, 3'd2, 6'd2, 7'd4};
  logic [5:0]  pos = '0;
  logic [31:0] left_acc = '0;
  logic [31:0] right_acc = '0;

  function automatic bit layout_ok(setting_t s);
    if (s.sb < 1 || s.sb > 4) return 0;
    if (s.fl && s.sb != 4) return 0;
    if (s.cc < 1) return 0;
    if (s.ba < 1 || s.ba > 64) return 0;
    return int'(s.ba) >= int'(s.sb) * int'(s.cc);
  endfunction

  // Single-precision product with 32767, rounded to nearest even, then
  // truncated toward zero. Done in integers so the host float unit is not involved.
  function automatic logic [15:0] float_to_s16(logic [31:0] w);
    logic [7:0]  ex;
    logic [23:0] mant;
    logic [63:0] prod, rnd, rem, half;
    int          e, len, s, k;
    logic [15:0] mag;
    ex = w[30:23];
    if (ex == 8'hFF && w[22:0] != 0) return 16'h0000;
    if (ex >= 8'd127) return w[31] ? 16'h8000 : 16'h7FFF;
    if (ex == 0 && w[22:0] == 0) return 16'h0000;
    mant = (ex == 0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]};
    e = (ex == 0) ? -126 : int'(ex) - 127;
    prod = 64'(mant) * 64'd32767;
    len = 0;
    for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
    s = (len > 24) ? len - 24 : 0;
    rnd = prod >> s;
    if (s > 0) begin
      rem = prod & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && rnd[0])) rnd = rnd + 1;
    end
    k = 23 - e - s;   // value is rnd / 2**k, always a right shift here
    mag = (k >= 64) ? 16'h0 : 16'(rnd >> k);
    return w[31] ? -mag : mag;
  endfunction

  function automatic logic [15:0] to_s16(logic [31:0] raw);
    if (cur.fl) return float_to_s16(raw);
    case (cur.sb)
      3'd1:    return {raw[7:0] ^ 8'h80, 8'h00};
      3'd2:    return raw[15:0];
      3'd3:    return raw[23:8];
      default: return raw[31:16];
    endcase
  endfunction

  task automatic frame_step(logic [7:0] b, logic last);
    int p;
    logic [15:0] l, r;
    p = pos;
    if (!layout_ok(cur)) begin
      pos = '0;
      return;
    end
    if (p < cur.sb) left_acc[(p % 4) * 8 +: 8] = b;
    else if (cur.cc > 1 && p < 2 * cur.sb) right_acc[((p - cur.sb) % 4) * 8 +: 8] = b;
    if (p + 1 >= cur.ba) begin
      l = to_s16(left_acc);
      r = (cur.cc > 1) ? to_s16(right_acc) : l;
      pair_q.push_back({r, l});
      pos = '0;
    end else begin
      pos = 6'(p + 1);
    end
    if (last) pos = '0;
  endtask

  // Byte driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= send_pct) begin
        in_tdata  <= byte_q[0].data;
        in_tlast  <= byte_q[0].last;
        in_tvalid <= 1'b1;
        void'(byte_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with a long hold-off whenever a new token is issued.
  int hold_cnt = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_cnt   <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_pct;
    end
  end

  // Monitor, checker and watchdog.
  int quiet = 0;
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) frame_step(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (pair_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pair %h", out_tdata);
        end else begin
          want = pair_q.pop_front();
          if (want[15:0] !== out_tdata[15:0] || want[31:16] !== out_tdata[31:16]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: left exp %h got %h, right exp %h got %h",
                       want[15:0], out_tdata[15:0], want[31:16], out_tdata[31:16]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else if (quiet >= 5000) begin
        $display("DONE: errors detected");
        $finish;
      end else
        quiet <= quiet + 1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    byte_item_t it;
    it.data = b;
    it.last = last;
    byte_q.push_back(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      pcmfs_pkg::REG_IS_FLOAT:     cur.fl = val[0];
      pcmfs_pkg::REG_SAMPLE_BYTES: cur.sb = val[2:0];
      pcmfs_pkg::REG_CHANNELS:     cur.cc = val[5:0];
      default:                     cur.ba = val;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(pcmfs_pkg::REG_IS_FLOAT, {6'd0, s.fl});
    write_reg(pcmfs_pkg::REG_SAMPLE_BYTES, {4'd0, s.sb});
    write_reg(pcmfs_pkg::REG_CHANNELS, {1'b0, s.cc});
    write_reg(pcmfs_pkg::REG_BLOCK_ALIGN, s.ba);
  endtask

  task automatic drain();
    while (byte_q.size() > 0 || in_tvalid || pair_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] sample_word();
    int r;
    r = $urandom_range(99);
    if (!cur.fl) begin
      if (r < 10) return 32'h0000_0000;
      if (r < 20) return 32'hFFFF_FFFF;
      if (r < 25) return 32'h8000_0000;
      if (r < 30) return 32'h7FFF_FFFF;
      return $urandom;
    end
    if (r < 45) return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
    if (r < 50) return {1'($urandom), 31'h3F80_0000};                    // exactly one
    if (r < 55) return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))}; // NaN
    if (r < 60) return {1'($urandom), 31'h7F80_0000};                    // infinity
    if (r < 65) return {1'($urandom), 8'h00, 23'($urandom)};             // denormal
    if (r < 70) return {1'($urandom), 31'h3F7F_FFFF};                    // just below one
    if (r < 75) return {1'($urandom), 31'h0};
    return $urandom;
  endfunction

  // Mostly whole frames with random content, some truncated ones and loose bytes.
  task automatic gen_bytes(int n);
    int count, r, len, ch;
    logic [31:0] words[32];
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (!layout_ok(cur) || r < 8) begin
        push_byte(8'($urandom), $urandom_range(3) == 0);
        count++;
      end else begin
        for (int c = 0; c < 32; c++) words[c] = sample_word();
        len = (r < 16 && cur.ba > 1) ? $urandom_range(1, cur.ba - 1) : cur.ba;
        for (int p = 0; p < len; p++) begin
          ch = p / cur.sb;
          push_byte((ch < cur.cc) ? words[ch][(p % cur.sb) * 8 +: 8] : 8'($urandom),
                    (p == len - 1) && (len < cur.ba || $urandom_range(9) == 0));
        end
        count += len;
      end
    end
  endtask

  setting_t plan[15];
  int       plan_bytes;

  initial begin
    plan = '{'{1'b0, 3'd1, 6'd1, 7'd1}, '{1'b0, 3'd3, 6'd2, 7'd6},
             '{1'b1, 3'd4, 6'd2, 7'd8}, '{1'b0, 3'd2, 6'd32, 7'd64},
             '{1'b0, 3'd7, 6'd63, 7'd127}, '{1'b0, 3'd4, 6'd3, 7'd13},
             '{1'b1, 3'd4, 6'd1, 7'd5}, '{1'b1, 3'd2, 6'd2, 7'd8},
             '{1'b0, 3'd1, 6'd2, 7'd3}, '{1'b0, 3'd0, 6'd1, 7'd4},
             '{1'b1, 3'd4, 6'd2, 7'd8}, '{1'b0, 3'd2, 6'd0, 7'd4},
             '{1'b0, 3'd3, 6'd1, 7'd3}, '{1'b0, 3'd2, 6'd2, 7'd3},
             '{1'b1, 3'd4, 6'd4, 7'd16}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset layout: 16-bit stereo, with extremes and packet ends mid-frame.
    push_byte(8'h00, 0); push_byte(8'h80, 0); push_byte(8'hFF, 0); push_byte(8'h7F, 0);
    push_byte(8'hFF, 0); push_byte(8'h7F, 0); push_byte(8'h00, 0); push_byte(8'h80, 0);
    push_byte(8'hFF, 0); push_byte(8'hFF, 1);
    push_byte(8'h12, 0); push_byte(8'h34, 0); push_byte(8'h56, 1);
    push_byte(8'hAA, 0); push_byte(8'h55, 0); push_byte(8'h01, 0); push_byte(8'hFE, 1);
    push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0);
    drain();

    for (int ph = 0; ph < 15; ph++) begin
      if (ph < 5) begin
        send_pct = 35; recv_pct = 79;
      end else if (ph < 10) begin
        send_pct = 79; recv_pct = 35;
      end else begin
        send_pct = 0; recv_pct = 0;
      end
      apply_setting(plan[ph]);
      plan_bytes = layout_ok(cur) ? 140 : 20;
      if (plan[ph].ba == 64) plan_bytes = 400;
      if (ph == 10) hold_token++;
      gen_bytes(plan_bytes);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
